### hdl/text_console_writer_core_assert.svh
// Assertion helpers for the checker file.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define TCW_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'd0;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd7;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_MOVE  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_WAIT,
    ST_IDLE,
    ST_SWEEP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              start;
    logic              scroll;
    logic [CELL_W-1:0] fill;
  } sweep_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_sts_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

### hdl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/tcw_sweep.sv
// Walks every cell once: a fill, or a scroll that copies each cell from one
// row below and fills the last row. Each copy write lands in the cycle after its read.
module tcw_sweep (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcw_pkg::sweep_cmd_t       cmd,
  input  logic [tcw_pkg::CELL_W-1:0] rd_data,
  output tcw_pkg::sweep_sts_t       sts,
  output tcw_pkg::ram_req_t         req
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);

  logic              active_r, active_nxt;
  logic              wr_v_r, wr_v_nxt;
  logic              scroll_r;
  logic [CELL_W-1:0] fill_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              wr_copy_r;
  logic              wr_last_r;
  logic              copy;

  assign copy = scroll_r && (cnt_r < COPY_END);

  always_comb begin
    active_nxt = active_r && (cnt_r != LAST_CELL);
    cnt_nxt    = active_r ? cnt_r + 1'b1 : cnt_r;
    wr_v_nxt   = active_r;
    if (cmd.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      wr_v_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      wr_v_r   <= wr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    wr_addr_r <= cnt_r;
    wr_copy_r <= copy;
    wr_last_r <= (cnt_r == LAST_CELL);
    if (cmd.start) begin
      scroll_r <= cmd.scroll;
      fill_r   <= cmd.fill;
    end
  end

  // raddr overflows only past the copy region, where re is low
  always_comb begin
    req.re    = active_r && copy;
    req.raddr = cnt_r + ADDR_W'(COLUMNS);
    req.we    = wr_v_r;
    req.waddr = wr_addr_r;
    req.wdata = wr_copy_r ? rd_data : fill_r;
  end

  assign sts.busy = active_r || wr_v_r;
  assign sts.done = wr_v_r && wr_last_r;

endmodule

### hdl/text_console_writer_core.sv
// 80x25 text console. One word is taken at a time: a put, move, read, or a
// newline that stays on screen is accepted, then written to the result register.
// A clear, or a newline or line wrap on the bottom row, runs the sweep unit
// over all 2000 cells through the single buffer write port first. After
// reset a clearing pass fills the buffer with spaces in attribute 7;
// in_tready stays low meanwhile, while writes to the attribute register
// are taken at any time.
module text_console_writer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0] in_tdata,   // ch[7:0], col[14:8], row[19:15]
  input  logic [tcw_pkg::MODE_W-1:0]    in_tuser,   // mode[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata, // cursor_col[6:0], cursor_row[11:7],
                                                    // scrolled[12], cell_char[20:13],
                                                    // cell_attr[28:21]
  input  logic                          cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata
);
  import tcw_pkg::*;

  state_t                state_r, state_nxt;
  logic [ATTR_W-1:0]     attr_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  scrolled_r, scrolled_nxt;
  logic                  rd_hit_r, rd_hit_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  mode_t             in_mode;
  logic [CHAR_W-1:0] in_ch;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic              wrap;
  logic              out_free;
  logic [CELL_W-1:0] rd_word;

  sweep_cmd_t        cmd;
  sweep_sts_t        sts;
  ram_req_t          top_req, sweep_req, ram_req;
  logic [CELL_W-1:0] ram_rdata;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
  endfunction

  assign in_mode  = mode_t'(in_tuser);
  assign in_ch    = in_tdata[7:0];
  assign in_col   = in_tdata[14:8];
  assign in_row   = in_tdata[19:15];
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_tvalid_r || out_tready;
  assign rd_word  = rd_hit_r ? ram_rdata : '0;

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    scrolled_nxt   = scrolled_r;
    rd_hit_nxt     = rd_hit_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    cmd            = '0;
    top_req        = '0;
    wrap           = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.start = 1'b1;
        cmd.fill  = {RESET_ATTR, SPACE_CHAR};
        state_nxt = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        if (sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          scrolled_nxt = 1'b0;
          rd_hit_nxt   = 1'b0;
          state_nxt    = ST_RESP;
          case (in_mode)
            MODE_PUT: begin
              if (in_ch == NEWLINE_CHAR) begin
                wrap = 1'b1;
              end else if (in_ch != NULL_CHAR) begin
                top_req.we    = 1'b1;
                top_req.waddr = cell_addr(row_r, col_r);
                top_req.wdata = {attr_r, in_ch};
                if (col_r >= LAST_COL) begin
                  wrap = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              if (wrap) begin
                col_nxt = '0;
                if (row_r >= LAST_ROW) begin
                  // bottom row: scroll, the sweep starts next cycle
                  row_nxt      = LAST_ROW;
                  scrolled_nxt = 1'b1;
                  cmd.start    = 1'b1;
                  cmd.scroll   = 1'b1;
                  cmd.fill     = {attr_r, SPACE_CHAR};
                  state_nxt    = ST_SWEEP;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            MODE_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = LAST_ROW;
              cmd.start = 1'b1;
              cmd.fill  = {attr_r, SPACE_CHAR};
              state_nxt = ST_SWEEP;
            end
            MODE_MOVE: begin
              col_nxt = (in_col > LAST_COL) ? LAST_COL : in_col;
              row_nxt = (in_row > LAST_ROW) ? LAST_ROW : in_row;
            end
            MODE_READ: begin
              if (in_col <= LAST_COL && in_row <= LAST_ROW) begin
                top_req.re    = 1'b1;
                top_req.raddr = cell_addr(in_row, in_col);
                rd_hit_nxt    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sts.done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {3'b000, rd_word[15:8], rd_word[7:0], scrolled_r, row_r, col_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      col_r        <= '0;
      row_r        <= LAST_ROW;
      out_tvalid_r <= 1'b0;
      attr_r       <= RESET_ATTR;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scrolled_r <= scrolled_nxt;
    rd_hit_r   <= rd_hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign ram_req = sts.busy ? sweep_req : top_req;

  tcw_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (ram_rdata),
    .sts     (sts),
    .req     (sweep_req)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_fb (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/tcw_chk.sv
`include "text_console_writer_core_assert.svh"

module tcw_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [tcw_pkg::MODE_W-1:0]     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcw_pkg::*;

  logic move_in_range;

  assign move_in_range = in_tvalid && in_tready && (in_tuser == MODE_MOVE)
                         && (in_tdata[14:8] < COL_W'(COLUMNS))
                         && (in_tdata[19:15] < ROW_W'(ROWS))
                         && (!out_tvalid || out_tready);

  // a stalled result word holds
  `TCW_ASSERT_ON(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // the buffer clearing pass keeps the input closed right after reset
  `TCW_ASSERT_ALWAYS(a_init_closed, !rst_n |=> !in_tready, "input open right after reset")

  // one word at a time
  `TCW_ASSERT_ON(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input open right after accept")

  // an in-range move shows up as the cursor in the registered result word, nothing else set
  `TCW_ASSERT_ON(a_move_result, move_in_range |-> ##2 out_tvalid && (out_tdata[6:0] == $past(in_tdata[14:8], 2)) && (out_tdata[11:7] == $past(in_tdata[19:15], 2)) && (out_tdata[28:12] == 17'd0), "move result mismatch")

endmodule

bind text_console_writer_core tcw_chk u_chk (.*);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int TAIL_CYCLES = 2100;

  // result word, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic [ATTR_W-1:0] cattr;
    logic [CHAR_W-1:0] cchar;
    logic              scrolled;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
  } console_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = MODE_PUT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [ATTR_W-1:0]     cfg_wdata = '0;

  text_console_writer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // shadow copy of the screen, cursor and attribute
  logic [CELL_W-1:0] shadow_fb [CELLS];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  console_status_t status_q [$];
  int              mismatches = 0;
  int              cycles = 0;
  int              hold_left = 0;
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;

  function automatic void fill_screen();
    for (int i = 0; i < CELLS; i++) shadow_fb[i] = {shadow_attr, SPACE_CHAR};
  endfunction

  function automatic bit advance_line();
    shadow_col = '0;
    if (shadow_row >= LAST_ROW) begin
      shadow_row = LAST_ROW;
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_fb[i] = shadow_fb[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_fb[i] = {shadow_attr, SPACE_CHAR};
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_status_t predict_status(mode_t m, logic [CHAR_W-1:0] c,
                                                     logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
    console_status_t s;
    int              idx;
    s = '0;
    case (m)
      MODE_PUT: begin
        if (c == NEWLINE_CHAR) begin
          s.scrolled = advance_line();
        end else if (c != NULL_CHAR) begin
          idx = int'(shadow_row) * COLUMNS + int'(shadow_col);
          shadow_fb[idx] = {shadow_attr, c};
          if (shadow_col == LAST_COL) s.scrolled = advance_line();
          else shadow_col = shadow_col + 1'b1;
        end
      end
      MODE_CLEAR: begin
        fill_screen();
        shadow_col = '0;
        shadow_row = LAST_ROW;
      end
      MODE_MOVE: begin
        shadow_col = (int'(x) < COLUMNS) ? x : LAST_COL;
        shadow_row = (int'(y) < ROWS) ? y : LAST_ROW;
      end
      default: begin
        if (int'(x) < COLUMNS && int'(y) < ROWS) begin
          idx = int'(y) * COLUMNS + int'(x);
          s.cchar = shadow_fb[idx][CHAR_W-1:0];
          s.cattr = shadow_fb[idx][CELL_W-1:CHAR_W];
        end
      end
    endcase
    s.ccol = shadow_col;
    s.crow = shadow_row;
    return s;
  endfunction

  // offer one word; returns in the step of the accepting edge with tvalid still high
  task automatic send_word(input mode_t m, input logic [CHAR_W-1:0] c,
                           input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    while (tx_idle_on && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {4'b0, y, x, c};
    status_q.push_back(predict_status(m, c, x, y));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_attr(input logic [ATTR_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    shadow_attr = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic do_reset();
    shadow_attr = RESET_ATTR;
    fill_screen();
    shadow_col = '0;
    shadow_row = LAST_ROW;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed();
    send_word(MODE_READ, 8'd0, 7'd0, 5'd0);
    send_word(MODE_READ, 8'd255, LAST_COL, LAST_ROW);
    send_word(MODE_READ, 8'd0, 7'h7F, 5'h1F);          // both out of range
    send_word(MODE_READ, 8'd0, 7'(COLUMNS), 5'd0);
    send_word(MODE_READ, 8'd0, 7'd0, 5'(ROWS));
    send_word(MODE_PUT, 8'd65, 7'd0, 5'd0);
    send_word(MODE_PUT, NULL_CHAR, 7'h7F, 5'h1F);      // null char: no change
    send_word(MODE_PUT, 8'd255, 7'd0, 5'd0);
    send_word(MODE_PUT, NEWLINE_CHAR, 7'd0, 5'd0);     // newline on bottom row scrolls
    send_word(MODE_READ, 8'd0, 7'd0, LAST_ROW - 1'b1);
    send_word(MODE_MOVE, 8'd0, 7'h7F, 5'h1F);          // saturates to the corner
    send_word(MODE_PUT, 8'd90, 7'd0, 5'd0);            // wrap on bottom row scrolls
    send_word(MODE_MOVE, 8'd0, 7'd0, 5'd0);
    send_word(MODE_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
    send_word(MODE_MOVE, 8'd0, LAST_COL, 5'd0);
    send_word(MODE_PUT, 8'd1, 7'd0, 5'd0);             // wrap without scroll
    set_attr(8'h00);
    send_word(MODE_PUT, 8'd113, 7'd0, 5'd0);
    send_word(MODE_READ, 8'd0, 7'd0, 5'd1);
    set_attr(8'hFF);
    send_word(MODE_CLEAR, 8'd0, 7'd0, 5'd0);
    send_word(MODE_READ, 8'd0, 7'd0, 5'd0);
    send_word(MODE_READ, 8'd0, LAST_COL, LAST_ROW);
  endtask

  // mostly text bursts, cursor moves and read-backs; a share of raw noise
  task automatic random_traffic(input int n);
    int sent;
    int k;
    int len;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) send_word(MODE_PUT, 8'($urandom_range(1, 255)),
                                                   7'($urandom), 5'($urandom));
          else send_word(MODE_PUT, 8'($urandom_range(32, 126)), 7'($urandom), 5'($urandom));
        end
        sent += len;
        if (shadow_col != 0 && $urandom_range(0, 1) == 0) begin
          send_word(MODE_READ, 8'($urandom), shadow_col - 1'b1, shadow_row);
          sent++;
        end
      end else if (k < 47) begin
        send_word(MODE_PUT, NEWLINE_CHAR, 7'($urandom), 5'($urandom));
        sent++;
      end else if (k < 62) begin
        if ($urandom_range(0, 2) == 0)
          send_word(MODE_MOVE, 8'($urandom), 7'($urandom_range(70, 79)),
                    5'($urandom_range(0, 24)));
        else
          send_word(MODE_MOVE, 8'($urandom), 7'($urandom_range(0, 79)),
                    5'($urandom_range(0, 24)));
        sent++;
      end else if (k < 82) begin
        send_word(MODE_READ, 8'($urandom), 7'($urandom_range(0, 79)),
                  5'($urandom_range(0, 24)));
        sent++;
      end else if (k < 84) begin
        send_word(MODE_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
        sent++;
      end else begin
        send_word(mode_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 5'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_attrs();
    logic [ATTR_W-1:0] attrs [4];
    attrs = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    foreach (attrs[i]) begin
      set_attr(attrs[i]);
      random_traffic(120);
    end
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_attr(8'($urandom));
    random_traffic(120);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_left = 600;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_word(MODE_READ, 8'($urandom), shadow_col, shadow_row);
      else send_word(MODE_PUT, 8'($urandom_range(32, 126)), 7'($urandom), 5'($urandom));
    end
    tx_idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= rx_idle_on ? ($urandom_range(0, 99) >= 7) : 1'b1;
    end
  end

  always @(posedge clk) begin
    console_status_t got;
    console_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: %h", out_tdata);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        if (got.ccol !== want.ccol || got.crow !== want.crow ||
            got.scrolled !== want.scrolled || got.cchar !== want.cchar ||
            got.cattr !== want.cattr) begin
          if (mismatches < 10)
            $display("mismatch col/row/scr/char/attr exp %0d/%0d/%0d/%h/%h got %0d/%0d/%0d/%h/%h",
                     want.ccol, want.crow, want.scrolled, want.cchar, want.cattr,
                     got.ccol, got.crow, got.scrolled, got.cchar, got.cattr);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_writer_core regression: fail");
      $finish;
    end
  end

  initial begin
    do_reset();
    test_directed();
    test_random_attrs();
    test_no_idle();
    test_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("text_console_writer_core regression: pass");
    end else begin
      $display("text_console_writer_core regression: fail");
    end
    $finish;
  end

endmodule
